@@ rtl/lcf_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// lcf_pkg: shared types and constants of the lcd color filter
// mixing matrix, channel types and the gamma response rom built at elaboration
// ---------------------------------------------------------------------------
package lcf_pkg;

    localparam int unsigned CH_W      = 8;
    localparam int unsigned COEF_W    = 8;
    localparam int unsigned PROD_W    = CH_W + COEF_W;
    localparam int unsigned SUM_W     = PROD_W + 2;
    localparam int unsigned MIX_SHIFT = 8;   // 0.8 fixed point coefficients, rows sum to 256
    localparam int unsigned CH_MAX    = (1 << CH_W) - 1;
    localparam int unsigned ROM_DEPTH = 1 << CH_W;

    typedef logic [CH_W-1:0]   t_chan;
    typedef logic [COEF_W-1:0] t_coef;
    typedef t_coef             t_mix_matrix [3][3];

    typedef struct packed {
        t_chan red;
        t_chan green;
        t_chan blue;
    } t_rgb;

    // rows: red, green, blue output; columns: red, green, blue input
    localparam t_mix_matrix MIX_COEF = '{
        '{8'd210, 8'd33,  8'd13 },
        '{8'd23,  8'd205, 8'd28 },
        '{8'd23,  8'd33,  8'd200}
    };

    // gamma 1.18 = 59/50; exact integer test, ties round up:
    // round(y) = count of k with (2k+1)^50 * 255^9 <= i^59 * 2^50
    localparam int unsigned GAMMA_NUM = 59;
    localparam int unsigned GAMMA_DEN = 50;
    localparam int unsigned BIG_W     = 544;

    typedef logic [ROM_DEPTH-1:0][CH_W-1:0] t_gamma_rom;

    function automatic t_gamma_rom build_gamma_rom();
        t_gamma_rom       rom;
        logic [BIG_W-1:0] rhs;
        logic [BIG_W-1:0] lhs;
        int unsigned      k;
        bit               searching;
        rom = '0;
        k   = 0;
        for (int unsigned i = 0; i < ROM_DEPTH; i++) begin
            rhs = BIG_W'(1);
            for (int unsigned n = 0; n < GAMMA_NUM; n++) begin
                rhs = rhs * BIG_W'(i);
            end
            rhs = rhs << GAMMA_DEN;
            searching = 1'b1;
            while (searching && (k < CH_MAX)) begin
                lhs = BIG_W'(1);
                for (int unsigned n = 0; n < GAMMA_DEN; n++) begin
                    lhs = lhs * BIG_W'(2 * k + 1);
                end
                for (int unsigned n = 0; n < GAMMA_NUM - GAMMA_DEN; n++) begin
                    lhs = lhs * BIG_W'(CH_MAX);
                end
                if (lhs <= rhs) begin
                    k = k + 1;
                end else begin
                    searching = 1'b0;
                end
            end
            rom[i] = CH_W'(k);
        end
        return rom;
    endfunction

    localparam t_gamma_rom GAMMA_ROM = build_gamma_rom();

endpackage
`default_nettype wire

@@ rtl/lcf_mix.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// lcf_mix: color correction matrix
// three 8x8 constant products per row, truncate by 256, saturate to 8 bits
// ---------------------------------------------------------------------------
module lcf_mix (
    input  wire lcf_pkg::t_rgb i_pix,
    output lcf_pkg::t_rgb      o_pix
);
    import lcf_pkg::*;

    localparam int unsigned Q_W = SUM_W - MIX_SHIFT;

    t_chan            ch   [3];
    t_chan            res  [3];
    logic [SUM_W-1:0] sum  [3];
    logic [Q_W-1:0]   quot [3];

    always_comb begin
        ch[0] = i_pix.red;
        ch[1] = i_pix.green;
        ch[2] = i_pix.blue;
        for (int r = 0; r < 3; r++) begin
            sum[r] = SUM_W'(PROD_W'(ch[0]) * PROD_W'(MIX_COEF[r][0]))
                   + SUM_W'(PROD_W'(ch[1]) * PROD_W'(MIX_COEF[r][1]))
                   + SUM_W'(PROD_W'(ch[2]) * PROD_W'(MIX_COEF[r][2]));
            quot[r] = sum[r][SUM_W-1:MIX_SHIFT];
            // saturate when anything above the low byte is set
            res[r]  = (|quot[r][Q_W-1:CH_W]) ? CH_W'(CH_MAX) : quot[r][CH_W-1:0];
        end
        o_pix.red   = res[0];
        o_pix.green = res[1];
        o_pix.blue  = res[2];
    end

endmodule
`default_nettype wire

@@ rtl/lcf_gamma.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// lcf_gamma: gamma response lookup
// one channel through the constant 256-entry response rom
// ---------------------------------------------------------------------------
module lcf_gamma (
    input  wire lcf_pkg::t_chan i_level,
    output lcf_pkg::t_chan      o_level
);
    import lcf_pkg::*;

    assign o_level = GAMMA_ROM[i_level];

endmodule
`default_nettype wire

@@ rtl/handheld_lcd_color_filter_core.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// handheld_lcd_color_filter_core: lcd color correction and gamma
// mixes rgb through a fixed 3x3 matrix, then applies gamma 1.18 per channel
// ---------------------------------------------------------------------------
//
//  channel   | handshake             | beat contents
//  ----------+-----------------------+----------------------------------------
//  pixel in  | i_valid / o_stall     | upper byte, red, green, blue, frame end
//  pixel out | o_valid / i_stall     | upper byte, r/g/b corrected, frame end
//
//  one beat per clock sustained while i_stall is low; a beat passes the input
//  register, then matrix + clamp + rom lookup into the output register
//  synchronous active-low reset empties both stages; payload is not reset
//  o_stall rises only when both stages hold a beat and i_stall is high, so a
//  finished pixel waiting downstream does not block the next input beat
//
module handheld_lcd_color_filter_core (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    // pixel in
    input  wire                 i_valid,
    output logic                o_stall,
    input  wire lcf_pkg::t_chan i_upper_byte,
    input  wire lcf_pkg::t_chan i_red_in,
    input  wire lcf_pkg::t_chan i_green_in,
    input  wire lcf_pkg::t_chan i_blue_in,
    input  wire                 i_frame_end,
    // pixel out
    output logic                o_valid,
    input  wire                 i_stall,
    output lcf_pkg::t_chan      o_upper_byte_out,
    output lcf_pkg::t_chan      o_red_out,
    output lcf_pkg::t_chan      o_green_out,
    output lcf_pkg::t_chan      o_blue_out,
    output logic                o_frame_end_out
);
    import lcf_pkg::*;

    // input stage
    logic  r_s1_valid;
    t_rgb  r_s1_pix;
    t_chan r_s1_upper;
    logic  r_s1_frame_end;

    // result stage
    logic  r_out_valid;
    t_rgb  r_out_pix;
    t_chan r_out_upper;
    logic  r_out_frame_end;

    logic  n_s1_valid;
    logic  n_out_valid;

    // stage advance: a stage moves when its successor can take the beat
    logic  out_adv;
    logic  s1_adv;

    t_rgb  mix_pix;
    t_rgb  gam_pix;

    assign out_adv = !r_out_valid || !i_stall;
    assign s1_adv  = !r_s1_valid || out_adv;
    assign o_stall = !s1_adv;

    // matrix with clamp, then per-channel gamma rom
    lcf_mix u_mix (
        .i_pix (r_s1_pix),
        .o_pix (mix_pix)
    );

    lcf_gamma u_gam_r (
        .i_level (mix_pix.red),
        .o_level (gam_pix.red)
    );

    lcf_gamma u_gam_g (
        .i_level (mix_pix.green),
        .o_level (gam_pix.green)
    );

    lcf_gamma u_gam_b (
        .i_level (mix_pix.blue),
        .o_level (gam_pix.blue)
    );

    always_comb begin
        n_s1_valid  = s1_adv ? i_valid : r_s1_valid;
        n_out_valid = out_adv ? r_s1_valid : r_out_valid;
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // payload, loaded only when the stage advances
    always_ff @(posedge i_clk) begin
        if (s1_adv && i_valid) begin
            r_s1_pix.red   <= i_red_in;
            r_s1_pix.green <= i_green_in;
            r_s1_pix.blue  <= i_blue_in;
            r_s1_upper     <= i_upper_byte;
            r_s1_frame_end <= i_frame_end;
        end
        if (out_adv && r_s1_valid) begin
            r_out_pix       <= gam_pix;
            r_out_upper     <= r_s1_upper;
            r_out_frame_end <= r_s1_frame_end;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_upper_byte_out = r_out_upper;
    assign o_red_out        = r_out_pix.red;
    assign o_green_out      = r_out_pix.green;
    assign o_blue_out       = r_out_pix.blue;
    assign o_frame_end_out  = r_out_frame_end;

endmodule
`default_nettype wire

@@ rtl/lcf_checker.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// lcf_checker: port-level checks of the lcd color filter
// reset, throughput, latency and output hold under stall
// ---------------------------------------------------------------------------
module lcf_checker (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    input  wire                 o_stall,
    input  wire lcf_pkg::t_chan i_upper_byte,
    input  wire lcf_pkg::t_chan i_red_in,
    input  wire lcf_pkg::t_chan i_green_in,
    input  wire lcf_pkg::t_chan i_blue_in,
    input  wire                 i_frame_end,
    input  wire                 o_valid,
    input  wire                 i_stall,
    input  wire lcf_pkg::t_chan o_upper_byte_out,
    input  wire lcf_pkg::t_chan o_red_out,
    input  wire lcf_pkg::t_chan o_green_out,
    input  wire lcf_pkg::t_chan o_blue_out,
    input  wire                 o_frame_end_out
);

    // reset empties the pipe
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output beat valid right after reset");

    // input is never held back while the output side flows
    a_no_stall_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_stall |-> !o_stall)
        else $error("input stalled while output not stalled");

    // accepted beat is valid at the output when i_stall is low while it sits in the input register
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) ##1 !i_stall |=> o_valid)
        else $error("accepted beat missing at output");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_red_out)
            && $stable(o_green_out) && $stable(o_blue_out)
            && $stable(o_upper_byte_out) && $stable(o_frame_end_out)))
        else $error("stalled output beat changed");

endmodule

bind handheld_lcd_color_filter_core lcf_checker u_lcf_checker (.*);
`default_nettype wire
